### rtl/core/p12h_pkg.sv
// ---------------------------------------------------------------------------
// p12h_pkg
// Shared widths, command codes and result kinds for the packed-12 unpacker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package p12h_pkg;

  localparam int BIN_COUNT     = 256;
  localparam int BIN_W         = $clog2(BIN_COUNT);
  localparam int COUNT_WIDTH   = 24;
  localparam int BIN_OUT_W     = 24;
  localparam int COUNT_EXT_W   = 32;
  localparam int CMD_W         = 2;
  localparam int BYTE_W        = 8;
  localparam int PIX_W         = 16;

  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DATA  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  localparam logic MODE_8BIT  = 1'b0;
  localparam logic MODE_12BIT = 1'b1;

endpackage

`default_nettype wire

### rtl/core/p12h_item_if.sv
// ---------------------------------------------------------------------------
// p12h_item_if
// Input channel: command, stream byte and bin index with valid/ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface p12h_item_if;
  logic                              valid;
  logic                              ready;
  logic [p12h_pkg::CMD_W-1:0]        command;
  logic [p12h_pkg::BYTE_W-1:0]       data_byte;
  logic [p12h_pkg::BIN_W-1:0]        bin_index;

  modport source (output valid, command, data_byte, bin_index, input ready);
  modport sink   (input valid, command, data_byte, bin_index, output ready);
endinterface

`default_nettype wire

### rtl/core/p12h_result_if.sv
// ---------------------------------------------------------------------------
// p12h_result_if
// Output channel: expanded pixel or histogram count with valid/ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface p12h_result_if;
  logic                              valid;
  logic                              ready;
  logic                              result_kind;
  logic [p12h_pkg::PIX_W-1:0]        pixel_value;
  logic [p12h_pkg::BIN_OUT_W-1:0]    bin_count;

  modport source (output valid, result_kind, pixel_value, bin_count, input ready);
  modport sink   (input valid, result_kind, pixel_value, bin_count, output ready);
endinterface

`default_nettype wire

### rtl/core/packed12_unpack_with_histogram.sv
// A pixel or bin-count result passes the registered bin-memory read, then the output register.
// Start-frame, held bytes and unused commands leave the input ready; an item that
//   touches the histogram (synchronous bin-memory read, then write-back for a pixel) holds it
//   off until it finishes. Output register decouples the sides; a stalled result holds the unit busy.
// Reset: histogram reads as empty (per-bin valid bits cleared), byte phase zero,
//   pixel_mode set to 12-bit packed.
// ---------------------------------------------------------------------------
// packed12_unpack_with_histogram
// Camera byte stream unpacker (8-bit / packed 12-bit) with a 256-bin histogram.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module packed12_unpack_with_histogram #(
  parameter int COUNT_WIDTH = p12h_pkg::COUNT_WIDTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic          cfg_wdata,
  p12h_item_if.sink          item,
  p12h_result_if.source      result
);

  localparam int BIN_W = p12h_pkg::BIN_W;

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  typedef struct packed {
    logic                          bump;
    logic                          kind;
    logic [p12h_pkg::PIX_W-1:0]    pixel;
  } op_t;

  logic                          pixel_mode;
  logic [1:0]                    byte_phase;
  logic [1:0]                    byte_phase_next;
  logic [p12h_pkg::BYTE_W-1:0]   held_byte;
  logic [p12h_pkg::BYTE_W-1:0]   held_byte_next;

  logic                          busy;
  op_t                           op;
  op_t                           op_next;
  logic [BIN_W-1:0]              op_bin;
  logic [BIN_W-1:0]              acc_bin;
  logic                          acc_mem;
  logic                          accept;

  logic [COUNT_WIDTH-1:0]        bin_mem [p12h_pkg::BIN_COUNT];
  logic [COUNT_WIDTH-1:0]        rd_data;
  logic                          rd_valid;
  logic [p12h_pkg::BIN_COUNT-1:0] bin_valid;
  logic [COUNT_WIDTH-1:0]        cur_count;
  logic [COUNT_WIDTH-1:0]        inc_count;
  logic [p12h_pkg::COUNT_EXT_W-1:0] count_ext;
  logic                          finish;
  logic [11:0]                   v12;

  logic                          out_valid;
  logic                          out_kind;
  logic [p12h_pkg::PIX_W-1:0]    out_pixel;
  logic [p12h_pkg::BIN_OUT_W-1:0] out_count;

  assign item.ready = !busy;
  assign accept     = item.valid && !busy;

  // decode of the accepted transaction
  always_comb begin
    byte_phase_next = byte_phase;
    held_byte_next  = held_byte;
    acc_mem         = 1'b0;
    acc_bin         = item.bin_index;
    op_next         = '0;
    v12             = '0;
    case (item.command)
      p12h_pkg::CMD_START: begin
        byte_phase_next = PH_FIRST;
        held_byte_next  = '0;
      end
      p12h_pkg::CMD_DATA: begin
        if (pixel_mode == p12h_pkg::MODE_8BIT) begin
          byte_phase_next = PH_FIRST;
          acc_mem         = 1'b1;
          acc_bin         = item.data_byte;
          op_next.bump    = 1'b1;
          op_next.kind    = p12h_pkg::KIND_PIXEL;
          op_next.pixel   = {item.data_byte, item.data_byte};
        end else begin
          case (byte_phase)
            PH_SECOND: begin
              v12             = {held_byte, item.data_byte[3:0]};
              held_byte_next  = item.data_byte;
              byte_phase_next = PH_THIRD;
              acc_mem         = 1'b1;
            end
            PH_THIRD: begin
              v12             = {item.data_byte, held_byte[7:4]};
              held_byte_next  = '0;
              byte_phase_next = PH_FIRST;
              acc_mem         = 1'b1;
            end
            default: begin
              held_byte_next  = item.data_byte;
              byte_phase_next = PH_SECOND;
            end
          endcase
          acc_bin       = v12[11:4];
          op_next.bump  = acc_mem;
          op_next.kind  = p12h_pkg::KIND_PIXEL;
          op_next.pixel = {v12, v12[11:8]};
        end
      end
      p12h_pkg::CMD_READ: begin
        acc_mem      = 1'b1;
        op_next.kind = p12h_pkg::KIND_COUNT;
      end
      default: begin
      end
    endcase
  end

  // finishing step: registered bin count is available
  assign finish    = busy && (!out_valid || result.ready);
  assign cur_count = rd_valid ? rd_data : '0;
  assign inc_count = (&cur_count) ? cur_count : cur_count + 1'b1;
  assign count_ext = p12h_pkg::COUNT_EXT_W'(cur_count);

  always_ff @(posedge clk) begin
    if (accept && acc_mem) begin
      rd_data <= bin_mem[acc_bin];
    end
    if (finish && op.bump) begin
      bin_mem[op_bin] <= inc_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_mode <= p12h_pkg::MODE_12BIT;
      byte_phase <= PH_FIRST;
      held_byte  <= '0;
      busy       <= 1'b0;
      bin_valid  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        pixel_mode <= cfg_wdata;
      end
      if (accept) begin
        byte_phase <= byte_phase_next;
        held_byte  <= held_byte_next;
        busy       <= acc_mem;
        if (item.command == p12h_pkg::CMD_START) begin
          bin_valid <= '0;
        end
      end
      if (finish) begin
        busy      <= 1'b0;
        out_valid <= 1'b1;
        if (op.bump) begin
          bin_valid[op_bin] <= 1'b1;
        end
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && acc_mem) begin
      op       <= op_next;
      op_bin   <= acc_bin;
      rd_valid <= bin_valid[acc_bin];
    end
    if (finish) begin
      out_kind  <= op.kind;
      out_pixel <= (op.kind == p12h_pkg::KIND_PIXEL) ? op.pixel : '0;
      out_count <= (op.kind == p12h_pkg::KIND_COUNT) ? count_ext[p12h_pkg::BIN_OUT_W-1:0] : '0;
    end
  end

  assign result.valid       = out_valid;
  assign result.result_kind = out_kind;
  assign result.pixel_value = out_pixel;
  assign result.bin_count   = out_count;

endmodule

`default_nettype wire

### tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Checks the packed-12 / 8-bit unpacker and its histogram. A behavioural model
// predicts each pixel and bin-count result per accepted transaction, and every
// result is compared field by field. Directed cases cover extreme bytes, every
// command, held bytes and mode changes. One long output stall and random frames
// follow, the frames with random idling on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic                           kind;
    logic [p12h_pkg::PIX_W-1:0]     pixel;
    logic [p12h_pkg::BIN_OUT_W-1:0] count;
  } unpack_result_t;

  // position within a packed 12-bit byte triple
  localparam logic [1:0] PHASE_FIRST  = 2'd0;
  localparam logic [1:0] PHASE_SECOND = 2'd1;
  localparam logic [1:0] PHASE_THIRD  = 2'd2;

  localparam logic [p12h_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic cfg_wdata;

  p12h_item_if   item ();
  p12h_result_if result ();

  packed12_unpack_with_histogram dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item),
    .result    (result)
  );

  // model state
  logic                             mdl_mode;
  logic [1:0]                       mdl_phase;
  logic [p12h_pkg::BYTE_W-1:0]      mdl_held;
  logic [p12h_pkg::COUNT_WIDTH-1:0] mdl_bins [p12h_pkg::BIN_COUNT];
  logic [p12h_pkg::BIN_W-1:0]       last_bin;

  unpack_result_t pending_results [$];
  int             mismatches = 0;
  bit             tx_idle = 1'b1;
  bit             rx_idle = 1'b1;
  int             rx_hold = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("[packed12_unpack_with_histogram] ERROR");
    $finish;
  end

  function automatic void clear_histogram();
    foreach (mdl_bins[i]) mdl_bins[i] = '0;
    mdl_phase = PHASE_FIRST;
    mdl_held  = '0;
  endfunction

  function automatic void count_bin(input logic [p12h_pkg::BIN_W-1:0] bin);
    if (mdl_bins[bin] != {p12h_pkg::COUNT_WIDTH{1'b1}}) begin
      mdl_bins[bin] = mdl_bins[bin] + 1'b1;
    end
    last_bin = bin;
  endfunction

  function automatic logic [p12h_pkg::PIX_W-1:0] expand12(input logic [11:0] v);
    count_bin(v[11:4]);
    return {v, v[11:8]};
  endfunction

  function automatic void expect_result(input unpack_result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void predict_transaction(input logic [p12h_pkg::CMD_W-1:0]  cmd,
                                              input logic [p12h_pkg::BYTE_W-1:0] b,
                                              input logic [p12h_pkg::BIN_W-1:0]  idx);
    unpack_result_t r;
    r = '0;
    case (cmd)
      p12h_pkg::CMD_START: begin
        clear_histogram();
      end
      p12h_pkg::CMD_READ: begin
        r.kind  = p12h_pkg::KIND_COUNT;
        r.count = mdl_bins[idx];
        expect_result(r);
      end
      p12h_pkg::CMD_DATA: begin
        r.kind = p12h_pkg::KIND_PIXEL;
        if (mdl_mode == p12h_pkg::MODE_8BIT) begin
          mdl_phase = PHASE_FIRST;
          count_bin(b);
          r.pixel = {b, b};
          expect_result(r);
        end else if (mdl_phase == PHASE_SECOND) begin
          r.pixel   = expand12({mdl_held, b[3:0]});
          mdl_held  = b;
          mdl_phase = PHASE_THIRD;
          expect_result(r);
        end else if (mdl_phase == PHASE_THIRD) begin
          r.pixel   = expand12({b, mdl_held[7:4]});
          mdl_held  = '0;
          mdl_phase = PHASE_FIRST;
          expect_result(r);
        end else begin
          // first byte of a triple is only held
          mdl_held  = b;
          mdl_phase = PHASE_SECOND;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(input logic [p12h_pkg::CMD_W-1:0]  cmd,
                           input logic [p12h_pkg::BYTE_W-1:0] b,
                           input logic [p12h_pkg::BIN_W-1:0]  idx);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      item.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item.valid     <= 1'b1;
    item.command   <= cmd;
    item.data_byte <= b;
    item.bin_index <= idx;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
    predict_transaction(cmd, b, idx);
  endtask

  task automatic send_byte(input logic [p12h_pkg::BYTE_W-1:0] b);
    send_item(p12h_pkg::CMD_DATA, b, p12h_pkg::BIN_W'($urandom));
  endtask

  task automatic read_bin(input logic [p12h_pkg::BIN_W-1:0] idx);
    send_item(p12h_pkg::CMD_READ, p12h_pkg::BYTE_W'($urandom), idx);
  endtask

  // wait for all results, then a pause in case a held byte is still in flight
  task automatic settle();
    @(negedge clk);
    item.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_pixel_mode(input logic m);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we    <= 1'b0;
    mdl_mode = m;
  endtask

  task automatic test_packed_directed();
    send_item(p12h_pkg::CMD_START, 8'hFF, 8'hFF);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hFF);
    read_bin(8'h00);
    read_bin(8'hFF);
    send_item(CMD_UNUSED, 8'hFF, 8'hFF);
    // a read between bytes of a triple leaves the phase alone
    send_byte(8'h7E);
    read_bin(8'h7E);
    send_byte(8'h4B);
    send_byte(8'hC3);
    // start frame drops a half-done triple
    send_byte(8'h55);
    send_item(p12h_pkg::CMD_START, 8'h00, 8'h00);
    send_byte(8'h12);
    send_byte(8'hA5);
    send_byte(8'hED);
    read_bin(8'h12);
    settle();
  endtask

  task automatic test_eight_bit_directed();
    // held byte is forgotten once a byte passes in 8-bit mode
    send_byte(8'h33);
    set_pixel_mode(p12h_pkg::MODE_8BIT);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    read_bin(8'hFF);
    set_pixel_mode(p12h_pkg::MODE_12BIT);
    send_byte(8'h9C);
    send_byte(8'h0F);
    send_byte(8'h61);
    read_bin(8'h9C);
    settle();
  endtask

  task automatic test_output_stall();
    set_pixel_mode(p12h_pkg::MODE_8BIT);
    tx_idle = 1'b0;
    rx_hold = 150;
    repeat (80) begin
      if ($urandom_range(0, 7) == 0) begin
        read_bin($urandom_range(0, 1) ? last_bin : p12h_pkg::BIN_W'($urandom));
      end else begin
        send_byte(p12h_pkg::BYTE_W'($urandom));
      end
    end
    settle();
    tx_idle = 1'b1;
  endtask

  task automatic test_random_frames();
    int                          sent;
    int                          sel;
    logic [p12h_pkg::BYTE_W-1:0] hot;
    for (int p = 0; p < 7; p++) begin
      set_pixel_mode((p % 2 == 0) ? p12h_pkg::MODE_12BIT : p12h_pkg::MODE_8BIT);
      tx_idle = (p != 3) && (p != 5);
      rx_idle = (p != 3);
      hot     = p12h_pkg::BYTE_W'($urandom);
      sent    = 0;
      send_item(p12h_pkg::CMD_START, p12h_pkg::BYTE_W'($urandom),
                p12h_pkg::BIN_W'($urandom));
      while (sent < 180) begin
        sel = $urandom_range(0, 99);
        if (sel < 2) begin
          send_item(p12h_pkg::CMD_START, p12h_pkg::BYTE_W'($urandom),
                    p12h_pkg::BIN_W'($urandom));
          sent++;
        end else if (sel < 5) begin
          send_item(CMD_UNUSED, p12h_pkg::BYTE_W'($urandom), p12h_pkg::BIN_W'($urandom));
        end else if (sel < 20) begin
          read_bin($urandom_range(0, 1) ? last_bin : p12h_pkg::BIN_W'($urandom));
          sent++;
        end else begin
          // a recurring byte lets some bins build up larger counts
          send_byte($urandom_range(0, 1) ? hot : p12h_pkg::BYTE_W'($urandom));
          sent++;
        end
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // result channel: random stalls per transaction, plus one long hold-off
  initial begin
    int stall;
    result.ready <= 1'b0;
    forever begin
      stall = rx_idle ? $urandom_range(0, 9) : 0;
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end
      @(negedge clk);
      if (stall > 0) begin
        result.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result.ready <= 1'b1;
      @(posedge clk);
      while (!result.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    unpack_result_t want;
    if (!rst && result.valid && result.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind=%0d pixel=%h count=%h", $time,
                 result.result_kind, result.pixel_value, result.bin_count);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (result.result_kind !== want.kind) begin
          $display("%0t: result_kind expected %0d, got %0d", $time, want.kind,
                   result.result_kind);
          mismatches++;
        end
        if (result.pixel_value !== want.pixel) begin
          $display("%0t: pixel_value expected %h, got %h", $time, want.pixel,
                   result.pixel_value);
          mismatches++;
        end
        if (result.bin_count !== want.count) begin
          $display("%0t: bin_count expected %h, got %h", $time, want.count,
                   result.bin_count);
          mismatches++;
        end
      end
    end
  end

  initial begin
    item.valid     <= 1'b0;
    item.command   <= p12h_pkg::CMD_START;
    item.data_byte <= '0;
    item.bin_index <= '0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= p12h_pkg::MODE_12BIT;
    mdl_mode = p12h_pkg::MODE_12BIT;
    last_bin = '0;
    clear_histogram();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_packed_directed();
    test_eight_bit_directed();
    test_output_stall();
    test_random_frames();
    settle();

    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("[packed12_unpack_with_histogram] OK");
    end else begin
      $display("[packed12_unpack_with_histogram] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/p12h_pkg.sv
rtl/core/p12h_item_if.sv
rtl/core/p12h_result_if.sv
rtl/core/packed12_unpack_with_histogram.sv
tb/testbench.sv
